// ===== rtl/mrfc_pkg.sv =====
// mrfc_pkg: shared types, codes and the byte-wide crc-16 update for the modbus rtu
// frame checker. No dependencies; every other file refers to it by scoped names.

package mrfc_pkg;

	localparam int unsigned QueueDepth = 4;
	localparam int unsigned PtrW       = $clog2(QueueDepth);
	localparam int unsigned CntW       = $clog2(QueueDepth + 1);

	localparam logic [15:0] CrcInit    = 16'hFFFF;
	localparam logic [15:0] CrcPoly    = 16'hA001;
	localparam logic [7:0]  FcReadHold = 8'h03;
	localparam logic [7:0]  FcWriteMul = 8'h10;
	localparam logic [7:0]  MinFrame   = 8'd4;
	localparam logic [7:0]  CountMax   = 8'hFF;
	localparam logic [7:0]  OwnAddrRst = 8'd1;

	localparam int unsigned AddrW = 3;
	localparam logic        RegOwnAddress = 1'b0;

	typedef enum logic [1:0] {
		VERDICT_ACCEPT     = 2'd0,
		VERDICT_ADDR_MISS  = 2'd1,
		VERDICT_TOO_SHORT  = 2'd2,
		VERDICT_CRC_MISS   = 2'd3
	} verdict_t;

	typedef enum logic [1:0] {
		CLASS_READ_HOLD = 2'd0,
		CLASS_WRITE_MUL = 2'd1,
		CLASS_ILLEGAL   = 2'd2
	} fclass_t;

	// one classified byte as it leaves the front end
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       feed_crc;
		logic       is_first;
		logic       is_second;
		logic [7:0] count;
	} item_t;

	typedef struct packed {
		verdict_t   verdict;
		logic [7:0] function_code;
		fclass_t    function_class;
		logic [7:0] frame_length;
	} result_t;

	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CrcPoly;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	function automatic fclass_t classify(input logic [7:0] code);
		fclass_t f;
		priority if (code == FcReadHold) begin
			f = CLASS_READ_HOLD;
		end else if (code == FcWriteMul) begin
			f = CLASS_WRITE_MUL;
		end else begin
			f = CLASS_ILLEGAL;
		end
		return f;
	endfunction

endpackage

// ===== rtl/mrfc_front.sv =====
// mrfc_front: accepts received bytes, tracks the frame byte count and tags each
// beat with its position in the frame. Depends on mrfc_pkg.

module mrfc_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [7:0]    rx_byte,
	input  logic          frame_last,
	input  logic          q_full,
	output logic          q_push,
	output mrfc_pkg::item_t q_item
);

	logic [7:0] count_q;
	logic [7:0] count_next;

	assign count_next = (count_q == mrfc_pkg::CountMax) ? count_q : count_q + 8'd1;

	assign q_push            = push && !q_full;
	assign q_item.data       = rx_byte;
	assign q_item.last       = frame_last;
	assign q_item.feed_crc   = (count_q >= 8'd2);
	assign q_item.is_first   = (count_q == 8'd0);
	assign q_item.is_second  = (count_q == 8'd1);
	assign q_item.count      = count_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 8'd0;
		end else if (q_push) begin
			count_q <= frame_last ? 8'd0 : count_next;
		end
	end

endmodule

// ===== rtl/mrfc_queue.sv =====
// mrfc_queue: short fifo of classified bytes between front and back ends.
// Depends on mrfc_pkg for the item type and depth.

module mrfc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  mrfc_pkg::item_t wr_item,
	input  logic            rd_en,
	output logic            full,
	output logic            valid,
	output mrfc_pkg::item_t rd_item
);

	mrfc_pkg::item_t              mem_q [mrfc_pkg::QueueDepth];
	logic [mrfc_pkg::PtrW-1:0]    wr_ptr_q;
	logic [mrfc_pkg::PtrW-1:0]    rd_ptr_q;
	logic [mrfc_pkg::CntW-1:0]    cnt_q;

	assign full    = (cnt_q == mrfc_pkg::CntW'(mrfc_pkg::QueueDepth));
	assign valid   = (cnt_q != '0);
	assign rd_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + mrfc_pkg::PtrW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + mrfc_pkg::PtrW'(1);
			end
			unique case ({wr_en, rd_en})
				2'b10:   cnt_q <= cnt_q + mrfc_pkg::CntW'(1);
				2'b01:   cnt_q <= cnt_q - mrfc_pkg::CntW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== rtl/mrfc_back.sv =====
// mrfc_back: runs the crc over delayed bytes, keeps the frame header and builds
// the verdict into the result register. Depends on mrfc_pkg.

module mrfc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        own_address,
	input  logic              q_valid,
	input  mrfc_pkg::item_t   q_item,
	output logic              q_pop,
	input  logic              pop,
	output logic              empty,
	output mrfc_pkg::result_t res
);

	logic [15:0]       crc_q;
	logic [7:0]        held0_q;
	logic [7:0]        held1_q;
	logic [7:0]        first_q;
	logic [7:0]        second_q;
	logic              res_valid_q;
	mrfc_pkg::result_t res_q;

	logic [15:0]        crc_n;
	logic [7:0]         first_n;
	logic [7:0]         second_n;
	mrfc_pkg::verdict_t verdict_n;
	logic               emit;

	assign q_pop = q_valid && (!q_item.last || !res_valid_q || pop);
	assign emit  = q_pop && q_item.last;
	assign empty = !res_valid_q;
	assign res   = res_q;

	always_comb begin
		crc_n    = q_item.feed_crc ? mrfc_pkg::crc_feed(crc_q, held1_q) : crc_q;
		first_n  = q_item.is_first  ? q_item.data : first_q;
		second_n = q_item.is_second ? q_item.data : second_q;
		priority if (first_n != own_address) begin
			verdict_n = mrfc_pkg::VERDICT_ADDR_MISS;
		end else if (q_item.count < mrfc_pkg::MinFrame) begin
			verdict_n = mrfc_pkg::VERDICT_TOO_SHORT;
		end else if (crc_n[7:0] == held0_q && crc_n[15:8] == q_item.data) begin
			verdict_n = mrfc_pkg::VERDICT_ACCEPT;
		end else begin
			verdict_n = mrfc_pkg::VERDICT_CRC_MISS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q    <= mrfc_pkg::CrcInit;
			held0_q  <= 8'd0;
			held1_q  <= 8'd0;
			first_q  <= 8'd0;
			second_q <= 8'd0;
		end else if (q_pop) begin
			if (q_item.last) begin
				crc_q    <= mrfc_pkg::CrcInit;
				held0_q  <= 8'd0;
				held1_q  <= 8'd0;
				first_q  <= 8'd0;
				second_q <= 8'd0;
			end else begin
				crc_q    <= crc_n;
				held0_q  <= q_item.data;
				held1_q  <= held0_q;
				first_q  <= first_n;
				second_q <= second_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit) begin
			res_valid_q <= 1'b1;
		end else if (pop) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q.verdict        <= verdict_n;
			res_q.function_code  <= second_n;
			res_q.function_class <= mrfc_pkg::classify(second_n);
			res_q.frame_length   <= q_item.count;
		end
	end

endmodule

// ===== rtl/modbus_rtu_frame_checker_top.sv =====
// modbus_rtu_frame_checker_top: modbus rtu frame checker, front end, byte queue,
// back end and the configuration register. Depends on mrfc_pkg and its submodules.
//
// Usage: received bytes enter through push/full, one beat per byte, with
// frame_last set on the final byte of each frame. Each frame gives one result
// beat on the empty/pop side: verdict, function code, its class and the frame
// length (saturating at 255). The crc-16 covers all bytes but the last two and
// is compared low byte first against them.
// Throughput: one byte per cycle while no final byte waits behind an unpopped
// result, set by the byte-wide crc update in the back end. A final byte passes
// through the byte queue and then into the registered result beat.
// The four-entry byte queue decouples the sides: while a result waits for pop,
// non-final bytes keep draining; the next final byte waits in the queue, and
// full rises once the queue holds four bytes.
// Reset clears the frame state, empties the queue and result register and sets
// own_address to 1. own_address is written at byte address 0 of the apb port
// and should change only while no frame is in flight.

module modbus_rtu_frame_checker_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [mrfc_pkg::AddrW-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	input  logic                       push,
	output logic                       full,
	input  logic [7:0]                 rx_byte,
	input  logic                       frame_last,
	output logic                       empty,
	input  logic                       pop,
	output logic [1:0]                 verdict,
	output logic [7:0]                 function_code,
	output logic [1:0]                 function_class,
	output logic [7:0]                 frame_length
);

	logic [7:0]        own_address_q;
	logic              q_push;
	logic              q_pop;
	logic              q_valid;
	mrfc_pkg::item_t   wr_item;
	mrfc_pkg::item_t   rd_item;
	mrfc_pkg::result_t res;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == mrfc_pkg::RegOwnAddress) ? {24'd0, own_address_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_address_q <= mrfc_pkg::OwnAddrRst;
		end else if (psel && penable && pwrite && paddr[2] == mrfc_pkg::RegOwnAddress) begin
			own_address_q <= pwdata[7:0];
		end
	end

	mrfc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.rx_byte    (rx_byte),
		.frame_last (frame_last),
		.q_full     (full),
		.q_push     (q_push),
		.q_item     (wr_item)
	);

	mrfc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_item (wr_item),
		.rd_en   (q_pop),
		.full    (full),
		.valid   (q_valid),
		.rd_item (rd_item)
	);

	mrfc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.own_address (own_address_q),
		.q_valid     (q_valid),
		.q_item      (rd_item),
		.q_pop       (q_pop),
		.pop         (pop),
		.empty       (empty),
		.res         (res)
	);

	assign verdict        = res.verdict;
	assign function_code  = res.function_code;
	assign function_class = res.function_class;
	assign frame_length   = res.frame_length;

endmodule

// ===== rtl/mrfc_checker.sv =====
// mrfc_checker: port-level assertions for the modbus rtu frame checker, bound to
// the top level. Depends on mrfc_pkg.

module mrfc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic [1:0] verdict,
	input logic [7:0] function_code,
	input logic [1:0] function_class,
	input logic [7:0] frame_length
);

	a_class_matches_code: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> ((function_code == mrfc_pkg::FcReadHold) ==
			(function_class == mrfc_pkg::CLASS_READ_HOLD)) &&
			((function_code == mrfc_pkg::FcWriteMul) ==
			(function_class == mrfc_pkg::CLASS_WRITE_MUL)))
		else $error("function class does not match function code");

	a_short_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && verdict == mrfc_pkg::VERDICT_TOO_SHORT) |->
			(frame_length < mrfc_pkg::MinFrame))
		else $error("too short verdict on a long frame");

	a_accept_length: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (verdict == mrfc_pkg::VERDICT_ACCEPT ||
			verdict == mrfc_pkg::VERDICT_CRC_MISS)) |->
			(frame_length >= mrfc_pkg::MinFrame))
		else $error("crc judged on a frame shorter than four bytes");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(verdict) && $stable(frame_length)))
		else $error("waiting result beat changed");

	a_length_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (frame_length != 8'd0))
		else $error("result beat with zero frame length");

endmodule

bind modbus_rtu_frame_checker_top mrfc_checker u_mrfc_checker (.*);

// ===== test/tb_modbus_rtu_frame_checker_top.sv =====
// tb_modbus_rtu_frame_checker_top: self-checking bench for the modbus rtu frame checker.
// Streams directed and random frames through the byte queue, predicts each verdict beat
// and checks it field by field. Depends on mrfc_pkg and modbus_rtu_frame_checker_top.

module tb_modbus_rtu_frame_checker_top;

	typedef logic [7:0] octets_t[$];

	typedef struct packed {
		logic [7:0] data;
		logic       eof;
	} rx_beat_t;

	typedef struct {
		mrfc_pkg::verdict_t verdict;
		logic [7:0]         code;
		mrfc_pkg::fclass_t  cls;
		logic [7:0]         len;
	} frame_result_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          psel = 1'b0;
	logic                          penable = 1'b0;
	logic                          pwrite = 1'b0;
	logic [mrfc_pkg::AddrW-1:0]    paddr = '0;
	logic [31:0]                   pwdata = '0;
	logic [31:0]                   prdata;
	logic                          pready;
	logic                          push = 1'b0;
	logic                          full;
	logic [7:0]                    rx_byte = '0;
	logic                          frame_last = 1'b0;
	logic                          empty;
	logic                          pop = 1'b0;
	logic [1:0]                    verdict;
	logic [7:0]                    function_code;
	logic [1:0]                    function_class;
	logic [7:0]                    frame_length;

	modbus_rtu_frame_checker_top dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.push(push), .full(full), .rx_byte(rx_byte), .frame_last(frame_last),
		.empty(empty), .pop(pop),
		.verdict(verdict), .function_code(function_code),
		.function_class(function_class), .frame_length(frame_length)
	);

	always #5 clk = ~clk;

	// frame checker state as predicted
	logic [7:0]  own_addr_m = mrfc_pkg::OwnAddrRst;
	logic [15:0] crc_m = mrfc_pkg::CrcInit;
	logic [7:0]  hold0_m = '0;
	logic [7:0]  hold1_m = '0;
	logic [7:0]  count_m = '0;
	logic [7:0]  first_m = '0;
	logic [7:0]  second_m = '0;

	rx_beat_t      rx_pending_q[$];
	frame_result_t verdict_expect_q[$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int stall_left = 0;
	int bytes_queued = 0;
	int bytes_accepted = 0;
	int frames_checked = 0;
	int addr_settings = 0;
	int mismatch_cnt = 0;
	int verdict_seen[4] = '{0, 0, 0, 0};

	function automatic logic [15:0] crc16_byte(input logic [15:0] acc, input logic [7:0] d);
		logic [15:0] r;
		r = acc;
		for (int i = 0; i < 8; i++) begin
			if (r[0] ^ d[i]) begin
				r = (r >> 1) ^ mrfc_pkg::CrcPoly;
			end else begin
				r = r >> 1;
			end
		end
		return r;
	endfunction

	function automatic void predict_rx(input logic [7:0] d, input logic eof);
		frame_result_t r;
		if (count_m == 8'd0) begin
			first_m = d;
		end else if (count_m == 8'd1) begin
			second_m = d;
		end
		if (count_m >= 8'd2) begin
			crc_m = crc16_byte(crc_m, hold1_m);
		end
		hold1_m = hold0_m;
		hold0_m = d;
		if (count_m != mrfc_pkg::CountMax) begin
			count_m = count_m + 8'd1;
		end
		if (eof) begin
			if (first_m != own_addr_m) begin
				r.verdict = mrfc_pkg::VERDICT_ADDR_MISS;
			end else if (count_m < mrfc_pkg::MinFrame) begin
				r.verdict = mrfc_pkg::VERDICT_TOO_SHORT;
			end else if ({hold0_m, hold1_m} == crc_m) begin
				r.verdict = mrfc_pkg::VERDICT_ACCEPT;
			end else begin
				r.verdict = mrfc_pkg::VERDICT_CRC_MISS;
			end
			r.code = second_m;
			if (second_m == mrfc_pkg::FcReadHold) begin
				r.cls = mrfc_pkg::CLASS_READ_HOLD;
			end else if (second_m == mrfc_pkg::FcWriteMul) begin
				r.cls = mrfc_pkg::CLASS_WRITE_MUL;
			end else begin
				r.cls = mrfc_pkg::CLASS_ILLEGAL;
			end
			r.len = count_m;
			verdict_expect_q.push_back(r);
			crc_m = mrfc_pkg::CrcInit;
			hold0_m = '0;
			hold1_m = '0;
			count_m = '0;
			first_m = '0;
			second_m = '0;
		end
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
		mismatch_cnt++;
	endtask

	// byte driver
	always @(posedge clk) begin : drive_rx
		rx_beat_t nxt;
		if (arst_n && push && !full) begin
			predict_rx(rx_byte, frame_last);
			bytes_accepted++;
		end
		if (!arst_n) begin
			push <= 1'b0;
		end else if (push && full) begin
			push <= 1'b1;
		end else if (rx_pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
			nxt = rx_pending_q.pop_front();
			push <= 1'b1;
			rx_byte <= nxt.data;
			frame_last <= nxt.eof;
		end else begin
			push <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end
	end

	// verdict monitor
	always @(posedge clk) begin : watch_results
		frame_result_t e;
		if (arst_n && pop && !empty) begin
			if (verdict_expect_q.size() == 0) begin
				report_mismatch("unexpected result beat, verdict", verdict, 0);
			end else begin
				e = verdict_expect_q.pop_front();
				if (verdict !== e.verdict) report_mismatch("verdict", verdict, e.verdict);
				if (function_code !== e.code)
					report_mismatch("function_code", function_code, e.code);
				if (function_class !== e.cls)
					report_mismatch("function_class", function_class, e.cls);
				if (frame_length !== e.len)
					report_mismatch("frame_length", frame_length, e.len);
				verdict_seen[e.verdict]++;
				frames_checked++;
			end
		end
		pop <= arst_n && stall_left == 0 && $urandom_range(99) >= recv_stall_pct;
	end

	task automatic cfg_write(input logic [7:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= mrfc_pkg::AddrW'(4 * mrfc_pkg::RegOwnAddress);
		pwdata <= {24'h0, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		own_addr_m = v;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[7:0] !== v) report_mismatch("own_address readback", prdata[7:0], v);
		psel <= 1'b0;
		penable <= 1'b0;
		addr_settings++;
	endtask

	task automatic add_frame(input octets_t fr);
		for (int i = 0; i < fr.size(); i++) begin
			rx_pending_q.push_back('{data: fr[i], eof: (i == fr.size() - 1)});
			bytes_queued++;
		end
	endtask

	function automatic octets_t rand_octets(input int n);
		octets_t q;
		q = {};
		repeat (n) q.push_back(8'($urandom));
		return q;
	endfunction

	task automatic add_crc_frame(input logic [7:0] addr, input logic [7:0] code,
			input octets_t payload, input bit corrupt);
		octets_t fr;
		logic [15:0] c;
		int k;
		fr = {};
		fr.push_back(addr);
		fr.push_back(code);
		foreach (payload[i]) fr.push_back(payload[i]);
		c = mrfc_pkg::CrcInit;
		foreach (fr[i]) c = crc16_byte(c, fr[i]);
		fr.push_back(c[7:0]);
		fr.push_back(c[15:8]);
		if (corrupt) begin
			k = $urandom_range(fr.size() - 1, 2);
			fr[k] = fr[k] ^ (8'h01 << $urandom_range(7));
		end
		add_frame(fr);
	endtask

	task automatic add_mixed_frame();
		octets_t fr;
		logic [7:0] addr;
		logic [7:0] code;
		int pick;
		int n;
		addr = ($urandom_range(99) < 85) ? own_addr_m : 8'($urandom);
		pick = $urandom_range(2);
		code = (pick == 0) ? mrfc_pkg::FcReadHold :
			(pick == 1) ? mrfc_pkg::FcWriteMul : 8'($urandom);
		pick = $urandom_range(99);
		if (pick < 60) begin
			add_crc_frame(addr, code, rand_octets($urandom_range(12)), 1'b0);
		end else if (pick < 75) begin
			add_crc_frame(addr, code, rand_octets($urandom_range(12)), 1'b1);
		end else begin
			n = (pick < 85) ? $urandom_range(3, 1) : $urandom_range(20, 1);
			fr = rand_octets(n - 1);
			fr.push_front(addr);
			add_frame(fr);
		end
	endtask

	task automatic wait_frames_drained();
		while (bytes_accepted != bytes_queued || verdict_expect_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

	initial begin : stimulus
		octets_t fr;
		int phase_start;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed frames, most of them at the reset address
		fr = '{own_addr_m};
		add_frame(fr);
		fr = '{own_addr_m, mrfc_pkg::FcReadHold};
		add_frame(fr);
		fr = '{8'hFF, mrfc_pkg::FcWriteMul, 8'h00};
		add_frame(fr);
		fr = {};
		add_crc_frame(own_addr_m, mrfc_pkg::FcWriteMul, fr, 1'b0);
		fr = '{8'h00, 8'hFF};
		add_crc_frame(own_addr_m, mrfc_pkg::FcReadHold, fr, 1'b0);
		add_crc_frame(own_addr_m, 8'h00, fr, 1'b1);
		fr = '{8'h00};
		add_frame(fr);
		wait_frames_drained();

		for (int p = 1; p <= 8; p++) begin
			unique case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
				default: begin send_idle_pct = 29; recv_stall_pct = 29; end
			endcase
			unique case (p)
				1, 6: cfg_write(8'd247);
				2: cfg_write(8'd0);
				3: cfg_write(8'd255);
				4, 8: cfg_write(8'd1);
				default: cfg_write(8'($urandom_range(247, 1)));
			endcase
			// long receiver hold-off so the byte queue backs up into full
			if (p == 4) stall_left <= 400;
			phase_start = bytes_queued;
			if (p == 2 || p == 6) begin
				add_crc_frame(own_addr_m, mrfc_pkg::FcWriteMul, rand_octets(262), p == 6);
			end
			while (bytes_queued - phase_start < 180) add_mixed_frame();
			wait_frames_drained();
		end

		$display("covered %0d bytes in %0d frames over %0d written address settings",
			bytes_accepted, frames_checked, addr_settings);
		$display("verdicts: %0d accepted, %0d address miss, %0d too short, %0d crc miss",
			verdict_seen[mrfc_pkg::VERDICT_ACCEPT], verdict_seen[mrfc_pkg::VERDICT_ADDR_MISS],
			verdict_seen[mrfc_pkg::VERDICT_TOO_SHORT], verdict_seen[mrfc_pkg::VERDICT_CRC_MISS]);
		if (mismatch_cnt == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
